// ===== hw/rtl/tdp_pkg.sv =====
// shared constants, types and state codes for the trial division prime tester
package tdp_pkg;

	localparam int VALUE_WIDTH = 16;
	localparam int SQ_WIDTH    = VALUE_WIDTH + 1;
	localparam int STEPS       = (VALUE_WIDTH + 1) / 2;
	localparam int PAD_WIDTH   = 2 * STEPS;
	localparam int CNT_WIDTH   = $clog2(STEPS + 1);

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [SQ_WIDTH-1:0]    square_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic step;
	} rem_ctl_t;

	typedef struct packed {
		logic last;
		logic zero;
	} rem_sts_t;

endpackage

// ===== hw/rtl/tdp_cand_if.sv =====
// request channel carrying one candidate number
interface tdp_cand_if;
	import tdp_pkg::*;

	logic   valid;
	logic   ready;
	value_t candidate;

	modport source (output valid, output candidate, input ready);
	modport sink   (input valid, input candidate, output ready);
endinterface

// ===== hw/rtl/tdp_res_if.sv =====
// result channel carrying the prime flag
interface tdp_res_if;
	logic valid;
	logic ready;
	logic is_prime;

	modport source (output valid, output is_prime, input ready);
	modport sink   (input valid, input is_prime, output ready);
endinterface

// ===== hw/rtl/tdp_rem_unit.sv =====
// shared remainder unit, restoring division two quotient bits per cycle
module tdp_rem_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  tdp_pkg::rem_ctl_t ctl,
	input  tdp_pkg::value_t   dividend,
	input  tdp_pkg::value_t   divisor,
	output tdp_pkg::rem_sts_t sts
);
	import tdp_pkg::*;

	logic [VALUE_WIDTH-1:0] rem_q;
	logic [PAD_WIDTH-1:0]   dvd_q;
	logic [CNT_WIDTH-1:0]   cnt_q;
	logic [VALUE_WIDTH:0]   r1_sh;
	logic [VALUE_WIDTH:0]   r1;
	logic [VALUE_WIDTH:0]   r2_sh;
	logic [VALUE_WIDTH:0]   r2;
	logic [VALUE_WIDTH:0]   div_ext;

	always_comb begin
		div_ext = {1'b0, divisor};
		r1_sh   = {rem_q, dvd_q[PAD_WIDTH-1]};
		r1      = (r1_sh >= div_ext) ? r1_sh - div_ext : r1_sh;
		r2_sh   = {r1[VALUE_WIDTH-1:0], dvd_q[PAD_WIDTH-2]};
		r2      = (r2_sh >= div_ext) ? r2_sh - div_ext : r2_sh;
		sts.last = (cnt_q == CNT_WIDTH'(STEPS - 1));
		sts.zero = (r2[VALUE_WIDTH-1:0] == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.start) begin
			cnt_q <= '0;
		end else if (ctl.step) begin
			cnt_q <= cnt_q + CNT_WIDTH'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			dvd_q <= PAD_WIDTH'(dividend);
		end else if (ctl.step) begin
			rem_q <= r2[VALUE_WIDTH-1:0];
			dvd_q <= dvd_q << 2;
		end
	end

endmodule

// ===== hw/rtl/trial_division_prime_test.sv =====
// trial division prime tester: sequencer, divisor and square tracking, result register
//
// usage: a candidate request enters on cand (valid/ready), one is_prime flag
// leaves on res (valid/ready) for every request, in order.
// cand.ready is high only while the sequencer is idle; one request is worked
// on at a time. divisors d = 2, 3, ... are tried while d*d <= candidate; d*d
// is kept by adding 2d+1 per trial. each trial is one compare in ST_CHECK and
// then STEPS = (VALUE_WIDTH+1)/2 steps in the shared remainder unit, which
// retires two quotient bits per cycle. candidates 0 and 1 skip the trials. the
// flag sits in an output register, so a new request is taken while an earlier
// flag waits; if res stays stalled the sequencer holds its finished flag until
// the register frees up.
// reset (arst_n low) returns the sequencer to idle, empties the output
// register and clears the remainder unit's step counter; nothing else is reset.
module trial_division_prime_test (
	input logic  clk,
	input logic  arst_n,
	tdp_cand_if.sink  cand,
	tdp_res_if.source res
);
	import tdp_pkg::*;

	state_t   state_q;
	state_t   state_d;
	value_t   n_q;
	value_t   d_q;
	square_t  sq_q;
	logic     flag_q;
	logic     out_valid_q;
	logic     out_flag_q;
	logic     sq_gt;
	logic     load_out;
	rem_ctl_t rem_ctl;
	rem_sts_t rem_sts;

	tdp_rem_unit u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (rem_ctl),
		.dividend (n_q),
		.divisor  (d_q),
		.sts      (rem_sts)
	);

	assign sq_gt = (sq_q > {1'b0, n_q});

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cand.valid) begin
					state_d = (cand.candidate < VALUE_WIDTH'(2)) ? ST_DONE : ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = sq_gt ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (rem_sts.last) begin
					state_d = rem_sts.zero ? ST_DONE : ST_CHECK;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cand.ready    = (state_q == ST_IDLE);
		rem_ctl.start = (state_q == ST_CHECK) && !sq_gt;
		rem_ctl.step  = (state_q == ST_DIV);
		load_out      = (state_q == ST_DONE) && (!out_valid_q || res.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cand.valid) begin
					n_q    <= cand.candidate;
					d_q    <= VALUE_WIDTH'(2);
					sq_q   <= SQ_WIDTH'(4);
					flag_q <= 1'b0;
				end
			end
			ST_CHECK: begin
				if (sq_gt) begin
					flag_q <= 1'b1;
				end
			end
			ST_DIV: begin
				if (rem_sts.last) begin
					if (rem_sts.zero) begin
						flag_q <= 1'b0;
					end else begin
						d_q  <= d_q + VALUE_WIDTH'(1);
						sq_q <= sq_q + {d_q, 1'b0} + SQ_WIDTH'(1);
					end
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_flag_q <= flag_q;
		end
	end

	assign res.valid    = out_valid_q;
	assign res.is_prime = out_flag_q;

	// divide only while d*d stays within the candidate
	a_div_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (sq_q <= {1'b0, n_q}))
		else $error("remainder step with divisor square above candidate");

	a_div_from_two: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_CHECK) |-> (d_q >= VALUE_WIDTH'(2)))
		else $error("trial divisor below two");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result register loaded outside the done state");

endmodule

// ===== bench/tb.sv =====
// testbench for the trial division prime tester: directed and random candidates, scoreboard
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tdp_pkg::*;

	localparam int RANDOM_ITEMS = 1700;
	localparam int PHASES       = 4;
	localparam int CYCLE_LIMIT  = (RANDOM_ITEMS + 25) * 12000;

	class prime_board;
		typedef struct {
			value_t cand;
			bit     flag;
		} expect_t;

		expect_t pending[$];
		int      errors;
		int      checked;
		int      primes;

		function new();
			errors  = 0;
			checked = 0;
			primes  = 0;
		endfunction

		function bit trial_prime(value_t v);
			longint unsigned n;
			longint unsigned d;
			n = v;
			if (n < 2)
				return 1'b0;
			for (d = 2; d * d <= n; d++)
				if (n % d == 0)
					return 1'b0;
			return 1'b1;
		endfunction

		task report(string what);
			$display("ERROR @%0t: %s", $realtime, what);
			errors++;
		endtask

		function void note(value_t v);
			expect_t e;
			e.cand = v;
			e.flag = trial_prime(v);
			pending = {pending, e};
		endfunction

		task check(logic got);
			expect_t e;
			if (pending.size() == 0) begin
				report($sformatf("flag %0b arrived with no request pending", got));
				return;
			end
			e = pending.pop_front();
			checked++;
			if (e.flag)
				primes++;
			if (got !== e.flag)
				report($sformatf("candidate %0d: is_prime %0b, want %0b", e.cand, got, e.flag));
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   cycles;
	int   send_idle;
	int   recv_stall;
	int   sent;

	prime_board board;

	tdp_cand_if cand_ch ();
	tdp_res_if  res_ch ();

	trial_division_prime_test dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cand   (cand_ch),
		.res    (res_ch)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("trial_division_prime_test: mismatch");
			$finish;
		end
	end

	// result side: random back-pressure
	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			board.check(res_ch.is_prime);
	end

	task automatic send_candidate(value_t v);
		bit done;
		done = 1'b0;
		while (!done) begin
			@(negedge clk);
			if ($urandom_range(99) < send_idle) begin
				cand_ch.valid <= 1'b0;
			end else begin
				cand_ch.valid     <= 1'b1;
				cand_ch.candidate <= v;
			end
			@(posedge clk);
			if (cand_ch.valid && cand_ch.ready) begin
				board.note(cand_ch.candidate);
				sent++;
				done = 1'b1;
			end
		end
	endtask

	function automatic value_t random_candidate();
		int     kind;
		int     w;
		int     a;
		int     b;
		value_t v;
		kind = $urandom_range(9);
		case (kind)
			0, 1, 2, 3: begin
				w = $urandom_range(1, VALUE_WIDTH);
				v = value_t'($urandom) & value_t'((32'h1 << w) - 1);
			end
			4, 5: begin
				a = $urandom_range(2, 255);
				b = a * a + $urandom_range(2) - 1;
				v = value_t'(b);
			end
			6, 7: begin
				a = $urandom_range(2, 255);
				b = $urandom_range(2, 65535 / a);
				v = value_t'(a * b);
			end
			8: begin
				v = value_t'($urandom);
			end
			default: begin
				v = value_t'($urandom_range(2, 4095) | 1);
			end
		endcase
		return v;
	endfunction

	initial begin
		value_t directed[$];
		int     phase;
		board             = new();
		cycles            = 0;
		sent              = 0;
		send_idle         = 0;
		recv_stall        = 0;
		arst_n            = 1'b0;
		cand_ch.valid     = 1'b0;
		cand_ch.candidate = '0;
		res_ch.ready      = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero and one, two and three, squares at the loop bound, extremes
		directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd25, 16'd49,
			16'd97, 16'd7919, 16'd32749, 16'd32768, 16'h5555, 16'hAAAA, 16'd63001,
			16'd64009, 16'd65025, 16'd65024, 16'd65497, 16'd65519, 16'd65521,
			16'd65534, 16'd65535};
		foreach (directed[i])
			send_candidate(directed[i]);

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 57; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 57; end
				default: begin send_idle = 26; recv_stall = 26; end
			endcase
			repeat (RANDOM_ITEMS / PHASES)
				send_candidate(random_candidate());
		end
		@(negedge clk);
		cand_ch.valid <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("%0d candidates tested over four idle and stall phases, %0d flags checked",
			sent, board.checked);
		$display("%0d primes seen, %0d errors", board.primes, board.errors);
		if (board.errors == 0)
			$display("trial_division_prime_test: match");
		else
			$display("trial_division_prime_test: mismatch");
		$finish;
	end

endmodule
